@@ hdl/range_adaptive_position_estimator_assert.svh @@
// Assertion macros for the range adaptive position estimator.
// Clock and reset are taken from the names clk and rst of the module that uses them.
`ifndef RANGE_ADAPTIVE_POSITION_ESTIMATOR_ASSERT_SVH
`define RANGE_ADAPTIVE_POSITION_ESTIMATOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define RPE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define RPE_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RPE_ASSERT(lbl, prop, msg)
`define RPE_ASSERT_RST(lbl, prop, msg)
`endif
`endif

@@ hdl/rpe_pkg.sv @@
// Shared types, constants, saturation and the microprogram of the position estimator.
// No dependencies; every module refers to it by scoped names.
package rpe_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int PC_W       = 6;

  localparam logic [PC_W-1:0] PC_DONE = 6'd32;

  localparam logic [22:0] FORGET_RST = 23'd65536;
  localparam logic [22:0] GAIN_RST   = 23'd65536;
  localparam logic [16:0] STEP_RST   = 17'd655;

  typedef logic signed [48:0] word_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FORGET_RATE = 2'd0,
    CFG_ADAPT_GAIN  = 2'd1,
    CFG_STEP_TIME   = 2'd2,
    CFG_TICK_LIMIT  = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {K_MUL, K_ALU, K_JSTOP, K_DONE} kind_t;
  typedef enum logic [1:0] {OP_ADD, OP_SUB, OP_SUBH, OP_MOV} op_t;
  typedef enum logic [1:0] {SAT_NONE, SAT_48, SAT_32} sat_t;

  typedef enum logic [3:0] {
    SRC_PX, SRC_PY, SRC_RNG, SRC_ALPHA, SRC_GAM, SRC_TS, SRC_RF, SRC_PFX,
    SRC_PFY, SRC_BX, SRC_BY, SRC_T0, SRC_T1, SRC_T2, SRC_T3, SRC_P
  } src_t;

  typedef enum logic [3:0] {
    DST_T0, DST_T1, DST_T2, DST_T3, DST_RF, DST_PFX, DST_PFY, DST_BX, DST_BY
  } dst_t;

  typedef struct packed {
    kind_t            kind;
    src_t             a;
    src_t             b;
    op_t              op;
    sat_t             sat;
    dst_t             dst;
    logic [PC_W-1:0]  target;
  } ucode_t;

  typedef struct packed {
    logic load_in;
    logic alu_we;
    logic tick;
    src_t a;
    src_t b;
    op_t  op;
    sat_t sat;
    dst_t dst;
  } ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

  localparam logic signed [49:0] MAX48 = (50'sd1 <<< 47) - 50'sd1;
  localparam logic signed [49:0] MIN48 = -(50'sd1 <<< 47);
  localparam logic signed [49:0] MAX32 = (50'sd1 <<< 31) - 50'sd1;
  localparam logic signed [49:0] MIN32 = -(50'sd1 <<< 31);

  function automatic word_t sat_res(input logic signed [49:0] v, input sat_t s);
    logic signed [49:0] r;
    r = v;
    case (s)
      SAT_48: begin
        if (v > MAX48) r = MAX48;
        else if (v < MIN48) r = MIN48;
      end
      SAT_32: begin
        if (v > MAX32) r = MAX32;
        else if (v < MIN32) r = MIN32;
      end
      default: r = v;
    endcase
    return r[48:0];
  endfunction

  function automatic ucode_t uc_mul(input src_t a, input src_t b);
    ucode_t u;
    u.kind   = K_MUL;
    u.a      = a;
    u.b      = b;
    u.op     = OP_MOV;
    u.sat    = SAT_NONE;
    u.dst    = DST_T0;
    u.target = '0;
    return u;
  endfunction

  function automatic ucode_t uc_alu(input op_t op, input src_t a, input src_t b,
                                    input dst_t dst, input sat_t sat);
    ucode_t u;
    u.kind   = K_ALU;
    u.a      = a;
    u.b      = b;
    u.op     = op;
    u.sat    = sat;
    u.dst    = dst;
    u.target = '0;
    return u;
  endfunction

  function automatic ucode_t uc_ctl(input kind_t kind, input logic [PC_W-1:0] target);
    ucode_t u;
    u.kind   = kind;
    u.a      = SRC_P;
    u.b      = SRC_P;
    u.op     = OP_MOV;
    u.sat    = SAT_NONE;
    u.dst    = DST_T0;
    u.target = target;
    return u;
  endfunction

  // T0 carries the half norm difference and then the range derivative,
  // T1 and T2 the position regressors, T3 the prediction, error and gain term.
  function automatic ucode_t ucode(input logic [PC_W-1:0] pc);
    ucode_t u;
    case (pc)
      6'd0:    u = uc_ctl(K_JSTOP, PC_DONE);
      6'd1:    u = uc_mul(SRC_PX, SRC_PX);
      6'd2:    u = uc_alu(OP_MOV, SRC_P, SRC_P, DST_T0, SAT_NONE);
      6'd3:    u = uc_mul(SRC_PY, SRC_PY);
      6'd4:    u = uc_alu(OP_ADD, SRC_T0, SRC_P, DST_T0, SAT_NONE);
      6'd5:    u = uc_mul(SRC_RNG, SRC_RNG);
      6'd6:    u = uc_alu(OP_SUBH, SRC_T0, SRC_P, DST_T0, SAT_NONE);
      6'd7:    u = uc_mul(SRC_ALPHA, SRC_RF);
      6'd8:    u = uc_alu(OP_SUB, SRC_T0, SRC_P, DST_T0, SAT_48);
      6'd9:    u = uc_mul(SRC_ALPHA, SRC_PFX);
      6'd10:   u = uc_alu(OP_SUB, SRC_PX, SRC_P, DST_T1, SAT_48);
      6'd11:   u = uc_mul(SRC_ALPHA, SRC_PFY);
      6'd12:   u = uc_alu(OP_SUB, SRC_PY, SRC_P, DST_T2, SAT_48);
      6'd13:   u = uc_mul(SRC_T0, SRC_TS);
      6'd14:   u = uc_alu(OP_ADD, SRC_RF, SRC_P, DST_RF, SAT_48);
      6'd15:   u = uc_mul(SRC_T1, SRC_TS);
      6'd16:   u = uc_alu(OP_ADD, SRC_PFX, SRC_P, DST_PFX, SAT_32);
      6'd17:   u = uc_mul(SRC_T2, SRC_TS);
      6'd18:   u = uc_alu(OP_ADD, SRC_PFY, SRC_P, DST_PFY, SAT_32);
      6'd19:   u = uc_mul(SRC_BX, SRC_T1);
      6'd20:   u = uc_alu(OP_MOV, SRC_P, SRC_P, DST_T3, SAT_NONE);
      6'd21:   u = uc_mul(SRC_BY, SRC_T2);
      6'd22:   u = uc_alu(OP_ADD, SRC_T3, SRC_P, DST_T3, SAT_48);
      6'd23:   u = uc_alu(OP_SUB, SRC_T0, SRC_T3, DST_T3, SAT_48);
      6'd24:   u = uc_mul(SRC_GAM, SRC_T3);
      6'd25:   u = uc_alu(OP_MOV, SRC_P, SRC_P, DST_T3, SAT_NONE);
      6'd26:   u = uc_mul(SRC_T3, SRC_T1);
      6'd27:   u = uc_mul(SRC_P, SRC_TS);
      6'd28:   u = uc_alu(OP_ADD, SRC_BX, SRC_P, DST_BX, SAT_32);
      6'd29:   u = uc_mul(SRC_T3, SRC_T2);
      6'd30:   u = uc_mul(SRC_P, SRC_TS);
      6'd31:   u = uc_alu(OP_ADD, SRC_BY, SRC_P, DST_BY, SAT_32);
      default: u = uc_ctl(K_DONE, PC_DONE);
    endcase
    return u;
  endfunction

endpackage

@@ hdl/range_adaptive_position_estimator.sv @@
// Range-only adaptive beacon position estimator, top level.
// Uses rpe_pkg, rpe_seq, rpe_dp and rpe_mul.
//
// Usage: each request on the s_ channel is one control tick carrying the
// own position and the measured beacon range; exactly one result request
// follows on the m_ channel with the beacon estimate and the estimating flag.
// Configuration registers are written on the cfg_ channel, which is always
// ready; write them only while no tick is in flight.
// Operation: a tick that runs the estimator walks a microprogram of 33 steps,
// 16 multiplies on the single shared multiplier and 17 ALU and control steps.
// Once estimation has stopped a tick jumps from the stop step to the last step.
// s_tready returns in the cycle in which m_tvalid rises, so a new tick is
// accepted only after the sequencer has finished the previous one.
// The result sits in an output register, so a new tick is accepted while it
// waits; if the receiver still stalls when the next result is ready, the
// sequencer holds at its last step until the output register is free.
// Reset clears the estimator state, restores the register defaults and
// leaves the block idle with m_tvalid low.
module range_adaptive_position_estimator (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [95:0]                        s_tdata,   // pos_x, pos_y, beacon_range
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [63:0]                        m_tdata,   // est_x, est_y
  output logic [0:0]                         m_tuser,   // estimating
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rpe_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rpe_pkg::CFG_DATA_W-1:0]     cfg_data
);

  rpe_pkg::ctl_t      ctl;
  rpe_pkg::mul_stat_t mst;
  rpe_pkg::word_t     opa;
  rpe_pkg::word_t     opb;
  logic               mul_go;
  logic signed [47:0] prod;
  logic signed [31:0] beacon_x;
  logic signed [31:0] beacon_y;
  logic               running;
  logic               run_after;
  logic               out_free;

  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;

  rpe_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .out_free (out_free),
    .running  (running),
    .mst      (mst),
    .mul_go   (mul_go),
    .ctl      (ctl)
  );

  rpe_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_pos_x  (s_tdata[31:0]),
    .in_pos_y  (s_tdata[63:32]),
    .in_range  (s_tdata[94:64]),
    .prod      (prod),
    .opa       (opa),
    .opb       (opb),
    .beacon_x  (beacon_x),
    .beacon_y  (beacon_y),
    .running   (running),
    .run_after (run_after)
  );

  rpe_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_go),
    .a     (opa),
    .b     (opb),
    .st    (mst),
    .prod  (prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctl.tick) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.tick) begin
      m_tdata <= {beacon_y, beacon_x};
      m_tuser <= run_after;
    end
  end

endmodule

@@ hdl/rpe_mul.sv @@
// Shared fixed-point multiplier: magnitude product from four 24 by 24 partial products,
// shifted right by 16 and saturated to 48 bits signed. Depends on rpe_pkg.
module rpe_mul (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  rpe_pkg::word_t       a,
  input  rpe_pkg::word_t       b,
  output rpe_pkg::mul_stat_t   st,
  output logic signed [47:0]   prod
);

  logic signed [48:0] a_abs;
  logic signed [48:0] b_abs;
  logic [47:0]        ma;
  logic [47:0]        mb;
  logic               neg;
  logic [2:0]         cnt;
  logic               busy;
  logic               done;
  logic [47:0]        pp;
  logic [1:0]         psh;
  logic [95:0]        acc;
  logic [23:0]        a_half;
  logic [23:0]        b_half;
  logic [47:0]        pp_c;
  logic [95:0]        pp_sh;
  logic [47:0]        mag;
  logic               hi_nz;

  assign a_abs  = a[48] ? (49'sd0 - a) : a;
  assign b_abs  = b[48] ? (49'sd0 - b) : b;
  assign a_half = cnt[1] ? ma[47:24] : ma[23:0];
  assign b_half = cnt[0] ? mb[47:24] : mb[23:0];
  assign pp_c   = {24'd0, a_half} * {24'd0, b_half};
  assign mag    = acc[63:16];
  assign hi_nz  = |acc[95:64];

  always_comb begin
    case (psh)
      2'd0:    pp_sh = {48'd0, pp};
      2'd1:    pp_sh = {24'd0, pp, 24'd0};
      default: pp_sh = {pp, 48'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == 3'd5) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ma  <= a_abs[47:0];
      mb  <= b_abs[47:0];
      neg <= a[48] ^ b[48];
      acc <= '0;
    end else if (busy) begin
      if (cnt <= 3'd3) begin
        pp  <= pp_c;
        psh <= {1'b0, cnt[1]} + {1'b0, cnt[0]};
      end
      if (cnt >= 3'd1 && cnt <= 3'd4) begin
        acc <= acc + pp_sh;
      end
      if (cnt == 3'd5) begin
        if (!neg) begin
          prod <= (hi_nz || mag[47]) ? 48'sh7FFF_FFFF_FFFF : $signed(mag);
        end else if (hi_nz || mag > 48'h8000_0000_0000) begin
          prod <= 48'sh8000_0000_0000;
        end else begin
          prod <= $signed(48'd0 - mag);
        end
      end
    end
  end

  assign st.busy = busy;
  assign st.done = done;

endmodule

@@ hdl/rpe_dp.sv @@
// Datapath of the estimator: configuration, estimator state, work registers,
// operand selection and a saturating adder and subtractor. Depends on rpe_pkg.
module rpe_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  rpe_pkg::ctl_t                     ctl,
  input  logic                              cfg_we,
  input  logic [rpe_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rpe_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic signed [31:0]                in_pos_x,
  input  logic signed [31:0]                in_pos_y,
  input  logic [30:0]                       in_range,
  input  logic signed [47:0]                prod,
  output rpe_pkg::word_t                    opa,
  output rpe_pkg::word_t                    opb,
  output logic signed [31:0]                beacon_x,
  output logic signed [31:0]                beacon_y,
  output logic                              running,
  output logic                              run_after
);

  logic [22:0]        forget_rate;
  logic [22:0]        adapt_gain;
  logic [16:0]        step_time;
  logic [23:0]        tick_limit;
  logic [23:0]        tick_count;
  logic [23:0]        tick_count_next;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic [30:0]        rng;
  logic signed [47:0] range_filter;
  logic signed [31:0] pos_filter_x;
  logic signed [31:0] pos_filter_y;
  logic signed [48:0] t0;
  logic signed [47:0] t1;
  logic signed [47:0] t2;
  logic signed [47:0] t3;
  logic signed [49:0] ea;
  logic signed [49:0] eb;
  logic signed [49:0] r;
  rpe_pkg::word_t     res;

  function automatic rpe_pkg::word_t pick(input rpe_pkg::src_t s);
    rpe_pkg::word_t v;
    unique case (s)
      rpe_pkg::SRC_PX:    v = {{17{pos_x[31]}}, pos_x};
      rpe_pkg::SRC_PY:    v = {{17{pos_y[31]}}, pos_y};
      rpe_pkg::SRC_RNG:   v = {18'd0, rng};
      rpe_pkg::SRC_ALPHA: v = {26'd0, forget_rate};
      rpe_pkg::SRC_GAM:   v = {26'd0, adapt_gain};
      rpe_pkg::SRC_TS:    v = {32'd0, step_time};
      rpe_pkg::SRC_RF:    v = {range_filter[47], range_filter};
      rpe_pkg::SRC_PFX:   v = {{17{pos_filter_x[31]}}, pos_filter_x};
      rpe_pkg::SRC_PFY:   v = {{17{pos_filter_y[31]}}, pos_filter_y};
      rpe_pkg::SRC_BX:    v = {{17{beacon_x[31]}}, beacon_x};
      rpe_pkg::SRC_BY:    v = {{17{beacon_y[31]}}, beacon_y};
      rpe_pkg::SRC_T0:    v = t0;
      rpe_pkg::SRC_T1:    v = {t1[47], t1};
      rpe_pkg::SRC_T2:    v = {t2[47], t2};
      rpe_pkg::SRC_T3:    v = {t3[47], t3};
      rpe_pkg::SRC_P:     v = {prod[47], prod};
    endcase
    return v;
  endfunction

  always_comb begin
    opa = pick(ctl.a);
    opb = pick(ctl.b);
  end

  assign ea = {opa[48], opa};
  assign eb = {opb[48], opb};

  always_comb begin
    unique case (ctl.op)
      rpe_pkg::OP_ADD:  r = ea + eb;
      rpe_pkg::OP_SUB:  r = ea - eb;
      rpe_pkg::OP_SUBH: r = (ea - eb) >>> 1;
      rpe_pkg::OP_MOV:  r = eb;
    endcase
    res = rpe_pkg::sat_res(r, ctl.sat);
  end

  assign tick_count_next = (tick_count == 24'hFF_FFFF) ? tick_count : tick_count + 24'd1;
  assign run_after       = running && (tick_count_next <= tick_limit);

  always_ff @(posedge clk) begin
    if (rst) begin
      forget_rate  <= rpe_pkg::FORGET_RST;
      adapt_gain   <= rpe_pkg::GAIN_RST;
      step_time    <= rpe_pkg::STEP_RST;
      tick_limit   <= '0;
      tick_count   <= '0;
      running      <= 1'b1;
      range_filter <= '0;
      pos_filter_x <= '0;
      pos_filter_y <= '0;
      beacon_x     <= '0;
      beacon_y     <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          rpe_pkg::CFG_FORGET_RATE: forget_rate <= cfg_data[22:0];
          rpe_pkg::CFG_ADAPT_GAIN:  adapt_gain  <= cfg_data[22:0];
          rpe_pkg::CFG_STEP_TIME:   step_time   <= cfg_data[16:0];
          rpe_pkg::CFG_TICK_LIMIT:  tick_limit  <= cfg_data;
        endcase
      end
      if (ctl.tick && running) begin
        tick_count <= tick_count_next;
        running    <= run_after;
      end
      if (ctl.alu_we) begin
        case (ctl.dst)
          rpe_pkg::DST_RF:  range_filter <= res[47:0];
          rpe_pkg::DST_PFX: pos_filter_x <= res[31:0];
          rpe_pkg::DST_PFY: pos_filter_y <= res[31:0];
          rpe_pkg::DST_BX:  beacon_x     <= res[31:0];
          rpe_pkg::DST_BY:  beacon_y     <= res[31:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      pos_x <= in_pos_x;
      pos_y <= in_pos_y;
      rng   <= in_range;
    end
    if (ctl.alu_we) begin
      case (ctl.dst)
        rpe_pkg::DST_T0: t0 <= res;
        rpe_pkg::DST_T1: t1 <= res[47:0];
        rpe_pkg::DST_T2: t2 <= res[47:0];
        rpe_pkg::DST_T3: t3 <= res[47:0];
        default: ;
      endcase
    end
  end

endmodule

@@ hdl/rpe_seq.sv @@
// Microprogram sequencer: step counter over the control store in rpe_pkg,
// multiply issue and wait, the stop jump and the handoff of each result.
`include "range_adaptive_position_estimator_assert.svh"
module rpe_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                out_free,
  input  logic                running,
  input  rpe_pkg::mul_stat_t  mst,
  output logic                mul_go,
  output rpe_pkg::ctl_t       ctl
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

  state_t                      state;
  logic [rpe_pkg::PC_W-1:0]    pc;
  logic                        issued;
  rpe_pkg::ucode_t             word;
  logic                        in_run;

  assign word     = rpe_pkg::ucode(pc);
  assign in_ready = (state == S_IDLE);
  assign in_run   = (state == S_RUN);
  assign mul_go   = in_run && (word.kind == rpe_pkg::K_MUL) && !issued;

  always_comb begin
    ctl.load_in = in_valid && in_ready;
    ctl.alu_we  = in_run && (word.kind == rpe_pkg::K_ALU);
    ctl.tick    = in_run && (word.kind == rpe_pkg::K_DONE) && out_free;
    ctl.a       = word.a;
    ctl.b       = word.b;
    ctl.op      = word.op;
    ctl.sat     = word.sat;
    ctl.dst     = word.dst;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      pc     <= '0;
      issued <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            pc    <= '0;
            state <= S_RUN;
          end
        end
        S_RUN: begin
          unique case (word.kind)
            rpe_pkg::K_ALU: pc <= pc + 1'b1;
            rpe_pkg::K_MUL: begin
              if (!issued) begin
                issued <= 1'b1;
              end else if (mst.done) begin
                issued <= 1'b0;
                pc     <= pc + 1'b1;
              end
            end
            rpe_pkg::K_JSTOP: pc <= running ? pc + 1'b1 : word.target;
            rpe_pkg::K_DONE: begin
              if (out_free) state <= S_IDLE;
            end
          endcase
        end
      endcase
    end
  end

  `RPE_ASSERT_RST(a_reset_idle, rst |=> (state == S_IDLE && !issued), "sequencer not idle after reset")
  `RPE_ASSERT(a_start_free, mul_go |-> !mst.busy, "multiply issued while multiplier busy")
  `RPE_ASSERT(a_done_issued, mst.done |-> issued, "multiply result without an issued multiply")
  `RPE_ASSERT(a_idle_clean, (state == S_IDLE) |-> !issued, "multiply pending while idle")
  `RPE_ASSERT(a_wait_holds, (in_run && word.kind == rpe_pkg::K_MUL && !mst.done) |=> $stable(pc), "step advanced before product ready")

endmodule
